/* hw/rtl/ipfl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and sizes for the index pool free list.
// Depends on nothing; every other file of the block but ipfl_ram imports it.
package ipfl_pkg;

	localparam int MAX_BUFFERS = 256;
	localparam int IDX_W       = $clog2(MAX_BUFFERS);
	localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);

	localparam int OP_W   = 2;
	localparam int STAT_W = 3;

	localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
	localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	localparam logic [STAT_W-1:0] ST_RESERVED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_UNCHANGED = 3'd1;
	localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
	localparam logic [STAT_W-1:0] ST_BUSY      = 3'd3;
	localparam logic [STAT_W-1:0] ST_ACQUIRED  = 3'd4;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;
	localparam logic [STAT_W-1:0] ST_RELEASED  = 3'd6;
	localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd7;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_fn_t;

	typedef struct packed {
		alu_fn_t          fn;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] value;
		logic             borrow;
	} alu_rsp_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  granted;
	} res_t;

endpackage

/* hw/rtl/ipfl_ram.sv */
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module ipfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/ipfl_alu.sv */
`timescale 1ns / 1ps
// Shared add / subtract unit; a subtraction also reports a borrow, which the
// sequencer uses for every compare. Depends on ipfl_pkg.
module ipfl_alu
	import ipfl_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic             sub;
	logic [CNT_W:0]   b_eff;
	logic [CNT_W:0]   sum;

	always_comb begin
		sub   = (req.fn == ALU_SUB);
		b_eff = {1'b0, req.b} ^ {(CNT_W + 1){sub}};
		sum   = {1'b0, req.a} + b_eff + {{CNT_W{1'b0}}, sub};
		rsp.value  = sum[CNT_W-1:0];
		// The extra top bit of a subtraction is the sign of a - b, so it is set
		// exactly when a < b.
		rsp.borrow = sub & sum[CNT_W];
	end

endmodule

/* hw/rtl/ipfl_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the free list: holds the pool counters, drives the shared ALU,
// the stack RAM and the free bitmap RAM. Depends on ipfl_pkg, ipfl_alu, ipfl_ram.
module ipfl_ctrl
	import ipfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [CNT_W-1:0]  count,
	input  logic [IDX_W-1:0]  index,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RSV_ZERO,
		S_RSV_MAX,
		S_RSV_POOL,
		S_RSV_BUSY,
		S_GROW_CHK,
		S_GROW_INC,
		S_ACQ_CHK,
		S_ACQ_RD,
		S_REL_CHK,
		S_REL_OUT,
		S_REL_PUSH,
		S_DONE
	} state_t;

	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BUFFERS);

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     index_q;
	logic [CNT_W-1:0]     pool_q;
	logic [CNT_W-1:0]     depth_q;
	logic [CNT_W-1:0]     out_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [STAT_W-1:0]    status_q;
	logic [IDX_W-1:0]     gnt_q;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [IDX_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [IDX_W-1:0]     ram_rdata;

	logic                 bmp_we;
	logic [IDX_W-1:0]     bmp_waddr;
	logic                 bmp_wdata;
	logic                 bmp_re;
	logic [IDX_W-1:0]     bmp_raddr;
	logic                 bmp_rdata;

	ipfl_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ipfl_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_BUFFERS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// One bit per index, set while the index sits on the stack. An entry is
	// written when its index joins the pool and is only looked at for indices
	// inside the pool, so it needs no clearing.
	ipfl_ram #(
		.WIDTH (1),
		.DEPTH (MAX_BUFFERS)
	) u_free_map (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (bmp_waddr),
		.wdata (bmp_wdata),
		.re    (bmp_re),
		.raddr (bmp_raddr),
		.rdata (bmp_rdata)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.granted = gnt_q;

	// ALU operands and RAM port controls for the current step.
	always_comb begin
		alu_req.fn = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		ram_we     = 1'b0;
		ram_waddr  = depth_q[IDX_W-1:0];
		ram_wdata  = index_q;
		ram_re     = 1'b0;
		ram_raddr  = alu_rsp.value[IDX_W-1:0];
		// The free bit of the offered index is read while idle, ready for the
		// release check in the next cycle.
		bmp_we     = 1'b0;
		bmp_waddr  = index_q;
		bmp_wdata  = 1'b0;
		bmp_re     = (state_q == S_IDLE);
		bmp_raddr  = index;
		case (state_q)
			S_RSV_ZERO: begin
				alu_req = '{fn: ALU_SUB, a: count_q, b: ONE};
			end
			S_RSV_MAX: begin
				alu_req = '{fn: ALU_SUB, a: MAX_CNT, b: count_q};
			end
			S_RSV_POOL: begin
				alu_req = '{fn: ALU_SUB, a: pool_q, b: count_q};
			end
			S_RSV_BUSY: begin
				alu_req = '{fn: ALU_SUB, a: out_q, b: ONE};
			end
			S_GROW_CHK: begin
				alu_req   = '{fn: ALU_SUB, a: ptr_q, b: count_q};
				ram_we    = alu_rsp.borrow;
				ram_waddr = ptr_q[IDX_W-1:0];
				ram_wdata = ptr_q[IDX_W-1:0];
				bmp_we    = alu_rsp.borrow;
				bmp_waddr = ptr_q[IDX_W-1:0];
				bmp_wdata = 1'b1;
			end
			S_GROW_INC: begin
				alu_req = '{fn: ALU_ADD, a: ptr_q, b: ONE};
			end
			S_ACQ_CHK: begin
				alu_req = '{fn: ALU_SUB, a: depth_q, b: ONE};
				ram_re  = ~alu_rsp.borrow;
			end
			S_ACQ_RD: begin
				alu_req   = '{fn: ALU_ADD, a: out_q, b: ONE};
				bmp_we    = 1'b1;
				bmp_waddr = ram_rdata;
				bmp_wdata = 1'b0;
			end
			S_REL_CHK: begin
				alu_req = '{fn: ALU_SUB, a: CNT_W'(index_q), b: pool_q};
			end
			S_REL_OUT: begin
				alu_req = '{fn: ALU_SUB, a: out_q, b: ONE};
			end
			S_REL_PUSH: begin
				alu_req   = '{fn: ALU_ADD, a: depth_q, b: ONE};
				ram_we    = 1'b1;
				bmp_we    = 1'b1;
				bmp_wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pool_q    <= '0;
			depth_q   <= '0;
			out_q     <= '0;
			status_q  <= ST_REJECTED;
			gnt_q     <= '0;
			count_q   <= '0;
			index_q   <= '0;
			ptr_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						count_q <= count;
						index_q <= index;
						gnt_q   <= '0;
						case (op)
							OP_RESERVE: state_q <= S_RSV_ZERO;
							OP_ACQUIRE: state_q <= S_ACQ_CHK;
							OP_RELEASE: state_q <= S_REL_CHK;
							default: begin
								status_q <= ST_REJECTED;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_RSV_ZERO: begin
					if (alu_rsp.borrow) begin
						status_q <= ST_INVALID;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RSV_MAX;
					end
				end
				S_RSV_MAX: begin
					if (alu_rsp.borrow) begin
						status_q <= ST_INVALID;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RSV_POOL;
					end
				end
				S_RSV_POOL: begin
					if (!alu_rsp.borrow) begin
						status_q <= ST_UNCHANGED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RSV_BUSY;
					end
				end
				S_RSV_BUSY: begin
					if (!alu_rsp.borrow) begin
						status_q <= ST_BUSY;
						state_q  <= S_DONE;
					end else begin
						ptr_q   <= pool_q;
						state_q <= S_GROW_CHK;
					end
				end
				S_GROW_CHK: begin
					if (alu_rsp.borrow) begin
						state_q <= S_GROW_INC;
					end else begin
						// Nothing was out, so the stack held the whole pool.
						pool_q   <= count_q;
						depth_q  <= count_q;
						status_q <= ST_RESERVED;
						state_q  <= S_DONE;
					end
				end
				S_GROW_INC: begin
					ptr_q   <= alu_rsp.value;
					state_q <= S_GROW_CHK;
				end
				S_ACQ_CHK: begin
					if (alu_rsp.borrow) begin
						status_q <= ST_EMPTY;
						state_q  <= S_DONE;
					end else begin
						depth_q <= alu_rsp.value;
						state_q <= S_ACQ_RD;
					end
				end
				S_ACQ_RD: begin
					out_q    <= alu_rsp.value;
					gnt_q    <= ram_rdata;
					status_q <= ST_ACQUIRED;
					state_q  <= S_DONE;
				end
				S_REL_CHK: begin
					// The free bit only counts for an index inside the pool.
					if (!alu_rsp.borrow || bmp_rdata) begin
						status_q <= ST_REJECTED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_REL_OUT;
					end
				end
				S_REL_OUT: begin
					if (alu_rsp.borrow) begin
						status_q <= ST_REJECTED;
						state_q  <= S_DONE;
					end else begin
						out_q   <= alu_rsp.value;
						state_q <= S_REL_PUSH;
					end
				end
				S_REL_PUSH: begin
					depth_q  <= alu_rsp.value;
					status_q <= ST_RELEASED;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/index_pool_free_list.sv */
`timescale 1ns / 1ps
// Top level of the index pool free list: the sequencer and the output register.
// Depends on ipfl_pkg and ipfl_ctrl (which holds ipfl_alu and ipfl_ram).
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------
//  input    | in_valid / in_ready  | op[1:0], count[8:0], index[7:0]
//  output   | out_valid / out_ready| status[2:0], granted_index[7:0]
//
// An item is taken and then worked through by a small sequencer around one
// shared add / subtract unit, one compare or update per cycle. A reserve that
// grows the pool works through the new indices one at a time, with a check and
// write step and an increment step for each. The sequencer is ready for the
// next item in the cycle after a result enters the output register.
// Reset clears the sequencer registers and out_valid, not the output payload.
// The stack RAM and the free bitmap RAM are not cleared: a free bit is written
// when its index joins the pool and is only read for indices inside it, and
// only stack entries that were pushed are popped. One item is in work at a
// time. The finished result sits in an output register, so the next item is
// accepted while an earlier result still waits on out_ready.
module index_pool_free_list
	import ipfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [CNT_W-1:0]  count,
	input  logic [IDX_W-1:0]  index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [IDX_W-1:0]  granted_index
);

	logic res_valid;
	logic res_ready;
	res_t res;

	logic out_valid_q;
	res_t out_q;

	ipfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.count     (count),
		.index     (index),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a new result whenever it is empty or its current
	// item is being taken in the same cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Payload only; it needs no reset.
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign granted_index = out_q.granted;

endmodule

/* hw/rtl/ipfl_checker.sv */
`timescale 1ns / 1ps
// Port level checks of the index pool free list, bound to the top level.
// Depends on ipfl_pkg and index_pool_free_list.
module ipfl_checker
	import ipfl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   op,
	input logic [CNT_W-1:0]  count,
	input logic [IDX_W-1:0]  index,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [IDX_W-1:0]  granted_index
);

	// A result that is not taken holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_index))
		else $error("result changed while stalled");

	// Only an acquire hands out an index.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_ACQUIRED) |-> granted_index == '0)
		else $error("index given with a non-acquire status");

	// One item at a time: the block is busy in the cycle after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

	// A request that is not a known kind never reaches the sequencer's
	// update paths and is refused.
	a_unknown_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op != OP_RESERVE) && (op != OP_ACQUIRE) &&
		(op != OP_RELEASE) && !out_valid |=> ##1 out_valid && (status == ST_REJECTED))
		else $error("unknown request not rejected");

endmodule

bind index_pool_free_list ipfl_checker u_ipfl_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for index_pool_free_list: a directed table and random traffic.
// Depends on ipfl_pkg and the RTL of the block.
module testbench;
	import ipfl_pkg::*;

	localparam int PERIOD      = 4;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1700;
	localparam int QUIET_ITEMS  = 200;
	localparam int SETTLE_CYCLES = 20;
	// A full growth from an empty pool moves no item on either side until it is
	// done; the limit must stay well above its length.
	localparam int STALL_LIMIT  = 4000;

	// The one op code that the package does not name.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] index;
	} pool_req_t;

	typedef struct packed {
		pool_req_t rq;
		logic      typed;
		res_t      res;
	} dir_row_t;

	localparam int DIR_N = 24;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [OP_W-1:0]   op;
	logic [CNT_W-1:0]  count;
	logic [IDX_W-1:0]  index;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  granted_index;

	index_pool_free_list dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.count         (count),
		.index         (index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_index (granted_index)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Private copy of the pool, advanced once for every accepted item.
	logic [IDX_W-1:0] free_stack [MAX_BUFFERS];
	logic             is_free    [MAX_BUFFERS];
	int               stack_depth;
	int               pool_size;
	int               out_count;

	// Results still owed by the block, oldest first.
	res_t pending_results [$];
	int   errors = 0;
	bit   quiet;

	// Requests lined up for the sender by the random part.
	pool_req_t drain_reqs [$];

	// The directed table. Rows marked typed carry the result that can be read off
	// at a glance; the others take the prediction of the pool copy.
	dir_row_t dir_rows [0:DIR_N-1] = '{
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b1, '{ST_EMPTY,     8'd0}},
		'{'{OP_RELEASE, 9'd0,   8'd0},   1'b1, '{ST_REJECTED,  8'd0}},
		'{'{OP_UNUSED,  9'd511, 8'd255}, 1'b1, '{ST_REJECTED,  8'd0}},
		'{'{OP_RESERVE, 9'd0,   8'd0},   1'b1, '{ST_INVALID,   8'd0}},
		'{'{OP_RESERVE, 9'd257, 8'd0},   1'b1, '{ST_INVALID,   8'd0}},
		'{'{OP_RESERVE, 9'd511, 8'd255}, 1'b1, '{ST_INVALID,   8'd0}},
		'{'{OP_RESERVE, 9'd4,   8'd0},   1'b1, '{ST_RESERVED,  8'd0}},
		'{'{OP_RESERVE, 9'd4,   8'd0},   1'b1, '{ST_UNCHANGED, 8'd0}},
		'{'{OP_RESERVE, 9'd1,   8'd0},   1'b1, '{ST_UNCHANGED, 8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b1, '{ST_ACQUIRED,  8'd3}},
		'{'{OP_RESERVE, 9'd6,   8'd0},   1'b1, '{ST_BUSY,      8'd0}},
		'{'{OP_RELEASE, 9'd0,   8'd3},   1'b1, '{ST_RELEASED,  8'd0}},
		'{'{OP_RELEASE, 9'd0,   8'd3},   1'b1, '{ST_REJECTED,  8'd0}},
		'{'{OP_RELEASE, 9'd0,   8'd4},   1'b1, '{ST_REJECTED,  8'd0}},
		'{'{OP_RELEASE, 9'd511, 8'd255}, 1'b1, '{ST_REJECTED,  8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b0, '{ST_ACQUIRED,  8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b0, '{ST_ACQUIRED,  8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b0, '{ST_ACQUIRED,  8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b0, '{ST_ACQUIRED,  8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b1, '{ST_EMPTY,     8'd0}},
		'{'{OP_RELEASE, 9'd0,   8'd2},   1'b0, '{ST_RELEASED,  8'd0}},
		'{'{OP_RELEASE, 9'd0,   8'd0},   1'b0, '{ST_RELEASED,  8'd0}},
		'{'{OP_ACQUIRE, 9'd0,   8'd0},   1'b0, '{ST_ACQUIRED,  8'd0}},
		'{'{OP_UNUSED,  9'd0,   8'd0},   1'b1, '{ST_REJECTED,  8'd0}}
	};

	// Works out the result of one request and moves the pool copy on.
	function automatic res_t pool_predict(pool_req_t rq);
		res_t r;
		int   i;
		r.status  = ST_REJECTED;
		r.granted = '0;
		case (rq.op)
			OP_RESERVE: begin
				if (rq.count == 0 || rq.count > MAX_BUFFERS) begin
					r.status = ST_INVALID;
				end else if (rq.count <= pool_size) begin
					r.status = ST_UNCHANGED;
				end else if (out_count != 0) begin
					r.status = ST_BUSY;
				end else begin
					// New indices go on in ascending order, so the highest ends on top.
					for (i = pool_size; i < rq.count; i++) begin
						if (stack_depth < MAX_BUFFERS) begin
							free_stack[stack_depth] = i[IDX_W-1:0];
							stack_depth++;
							is_free[i] = 1'b1;
						end
					end
					pool_size = rq.count;
					r.status  = ST_RESERVED;
				end
			end
			OP_ACQUIRE: begin
				if (stack_depth == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stack_depth--;
					r.granted          = free_stack[stack_depth];
					is_free[r.granted] = 1'b0;
					out_count++;
					r.status = ST_ACQUIRED;
				end
			end
			OP_RELEASE: begin
				// Outside the pool, a double free, or nothing out at all: refused.
				if (rq.index < pool_size && !is_free[rq.index] && out_count != 0) begin
					if (stack_depth < MAX_BUFFERS) begin
						free_stack[stack_depth] = rq.index;
						stack_depth++;
						is_free[rq.index] = 1'b1;
					end
					out_count--;
					r.status = ST_RELEASED;
				end
			end
			default: r.status = ST_REJECTED;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Lines up one request at the back of the sender's queue.
	task automatic stage_req(pool_req_t rq);
		drain_reqs.insert(drain_reqs.size(), rq);
	endtask

	// Offers one item from a falling edge and holds it until it is taken. Before
	// the item the sender may idle for a short burst, unless the run is in its
	// quiet tail. The valid stays high on return, so that a following item goes
	// out back to back.
	task automatic send_request(pool_req_t rq, logic typed, res_t typed_res);
		res_t predicted;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1'b1;
		op       = rq.op;
		count    = rq.count;
		index    = rq.index;
		do @(posedge clk); while (!in_ready);
		predicted = pool_predict(rq);
		pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// Holds the sender back until every owed result has come out.
	task automatic wait_for_results;
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// The receiver stalls in random bursts, and never in the quiet tail of the
	// run.
	int stall_left = 0;
	always @(negedge clk) begin
		if (quiet) begin
			out_ready = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			out_ready  = 1'b0;
		end else begin
			out_ready = 1'b1;
		end
	end

	// Every result taken is compared with the oldest one owed.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("status of a result with none owed", status, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (granted_index !== want.granted)
					report_mismatch("granted_index", granted_index, want.granted);
			end
		end
	end

	// The run is ended if nothing moves on either side for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		pool_req_t rq;
		res_t      no_res;
		int        sent;
		int        start;
		int        i;
		int        k;
		int        target;
		int        pick;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_RESERVE;
		count       = '0;
		index       = '0;
		quiet       = 1'b0;
		no_res      = '0;
		stack_depth = 0;
		pool_size   = 0;
		out_count   = 0;
		for (i = 0; i < MAX_BUFFERS; i++) begin
			is_free[i]    = 1'b0;
			free_stack[i] = '0;
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: the edges of every field, every request kind, growth,
		// refusal while indices are out, double frees and releases outside the pool.
		for (i = 0; i < DIR_N; i++)
			send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);

		wait_for_results();

		// Random part. Most traffic is acquires and releases of indices that are
		// really out, so that the stack is driven deep; now and then every index
		// is handed back and the pool is grown, which is the only way past a busy
		// refusal. Stray releases, odd counts and the unused op are the noise.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == RANDOM_ITEMS / 2)
				wait_for_results();
			quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);

			if (drain_reqs.size() == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					if (pool_size > 0) begin
						start = $urandom_range(0, pool_size - 1);
						for (k = 0; k < pool_size; k++) begin
							i = (start + k) % pool_size;
							if (!is_free[i])
								stage_req('{OP_RELEASE, 9'($urandom_range(0, 511)),
									8'(i)});
						end
					end
					if (pool_size >= MAX_BUFFERS)
						target = $urandom_range(1, MAX_BUFFERS);
					else if ($urandom_range(0, 19) == 0)
						target = MAX_BUFFERS;
					else
						target = pool_size + $urandom_range(1, 12);
					if (target > MAX_BUFFERS)
						target = MAX_BUFFERS;
					stage_req('{OP_RESERVE, 9'(target), 8'($urandom_range(0, 255))});
				end else if (pick < 8) begin
					stage_req('{OP_RESERVE, 9'($urandom_range(0, 511)),
						8'($urandom_range(0, 255))});
				end else if (pick < 50) begin
					stage_req('{OP_ACQUIRE, 9'($urandom_range(0, 511)),
						8'($urandom_range(0, 255))});
				end else if (pick < 90) begin
					rq = '{OP_RELEASE, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255))};
					// Mostly hand back an index that is out, found by a scan from a
					// random place in the pool.
					if (out_count > 0 && $urandom_range(0, 9) != 0) begin
						start = $urandom_range(0, pool_size - 1);
						for (k = 0; k < pool_size; k++) begin
							i = (start + k) % pool_size;
							if (!is_free[i]) begin
								rq.index = 8'(i);
								break;
							end
						end
					end
					stage_req(rq);
				end else begin
					stage_req('{OP_UNUSED, 9'($urandom_range(0, 511)),
						8'($urandom_range(0, 255))});
				end
			end

			rq = drain_reqs.pop_front();
			send_request(rq, 1'b0, no_res);
			sent++;
		end

		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// A settling wait catches any result that the block should not give.
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
